// File: src/scba_pkg.sv
// Shared types and constants for the size class bitmap block allocator.
`default_nettype none
package scba_pkg;

  localparam int ADDR_W   = 64;
  localparam int PAGES_W  = 16;
  localparam int CLS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 72;
  localparam int OUT_PAD  = OUT_W - ADDR_W - STATUS_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_OWNED  = 3'd4,
    ST_MISALIGNED = 3'd5
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [0:0] {
    REG_AREA_START = 1'b0,
    REG_AREA_BYTES = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// File: src/size_class_bitmap_block_allocator_top.sv
// Top level of the size class bitmap block allocator.
// An allocation of class c steps through pools 0 to c in states S_GAP, S_COUNT, S_TEST;
// a free stops at the owning pool or tries all pools for an unowned address, and a zero
// or oversized request goes straight to S_DONE. One shared pool-geometry datapath visits
// the pools in turn. One request is in flight at a time; a new one is taken once the
// result is registered. Writing area_bytes starts a division by the pool count that
// holds off input transfers. Synchronous reset clears all bitmaps and both registers.
`default_nettype none
module size_class_bitmap_block_allocator_top
  import scba_pkg::*;
#(
  parameter int POOLS      = 8,
  parameter int BLOCKS     = 64,
  parameter int PAGE_SHIFT = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // page_count, free_address
  input  logic              s_tuser,   // mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // block_address, status
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW = $clog2(BLOCKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_COUNT,
    S_TEST,
    S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] area_start;
  logic [ADDR_W-1:0] share;
  logic              div_start;
  logic              div_busy;

  mode_t             mode_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CLS_W-1:0]  cls;
  logic [PW-1:0]     pool;
  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] gap;
  logic [ADDR_W-1:0] first;
  logic [CW-1:0]     count;
  logic [BLOCKS-1:0] maps [POOLS];

  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic [ADDR_W-1:0] out_addr;
  status_t           out_status;

  logic [PAGES_W-1:0] page_count;
  logic [ADDR_W-1:0]  free_address;
  logic [PAGES_W-1:0] pm1;
  logic [CLS_W-1:0]   cls_in;
  logic [CLS_W-1:0]   shamt;
  logic [ADDR_W-1:0]  bmask;
  logic [ADDR_W-1:0]  gap_in;
  logic [ADDR_W-1:0]  rem;
  logic [ADDR_W-1:0]  craw;
  logic [CW-1:0]      count_in;
  logic [BLOCKS-1:0]  usable;
  logic [BLOCKS-1:0]  freebits;
  logic [IW-1:0]      low_idx;
  logic [ADDR_W-1:0]  alloc_addr;
  logic [ADDR_W-1:0]  limit;
  logic [ADDR_W-1:0]  off;
  logic [ADDR_W-1:0]  blk;
  logic               owned;
  logic               aligned;
  logic               is_last;
  logic               at_cls;

  assign page_count   = s_tdata[PAGES_W-1:0];
  assign free_address = s_tdata[PAGES_W +: ADDR_W];
  assign div_start    = cfg_we && (cfg_index == REG_AREA_BYTES);
  assign s_tready     = (state == S_IDLE) && !div_busy && !cfg_we;
  assign m_tdata      = {OUT_PAD'(0), out_status, out_addr};

  scba_div #(
    .DIVISOR (POOLS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg_data),
    .busy     (div_busy),
    .quotient (share)
  );

  always_comb begin
    pm1    = page_count - PAGES_W'(1);
    cls_in = '0;
    for (int b = 0; b < PAGES_W; b++) begin
      if (pm1[b]) begin
        cls_in = CLS_W'(b + 1);
      end
    end
    if (page_count <= PAGES_W'(1)) begin
      cls_in = '0;
    end
  end

  always_comb begin
    shamt  = CLS_W'(pool) + CLS_W'(PAGE_SHIFT);
    bmask  = (ADDR_W'(1) << shamt) - ADDR_W'(1);
    gap_in = (~start + ADDR_W'(1)) & bmask;
    rem    = share - gap;
    craw   = rem >> shamt;
    if (gap >= share) begin
      count_in = '0;
    end else if (craw > ADDR_W'(BLOCKS)) begin
      count_in = CW'(BLOCKS);
    end else begin
      count_in = craw[CW-1:0];
    end
  end

  always_comb begin
    for (int b = 0; b < BLOCKS; b++) begin
      usable[b] = b < int'(count);
    end
    freebits = ~maps[pool] & usable;
    low_idx  = '0;
    for (int b = BLOCKS - 1; b >= 0; b--) begin
      if (freebits[b]) begin
        low_idx = IW'(b);
      end
    end
    alloc_addr = first + (ADDR_W'(low_idx) << shamt);
    limit      = ADDR_W'(count) << shamt;
    off        = addr_r - first;
    owned      = off < limit;
    aligned    = (off & bmask) == '0;
    blk        = off >> shamt;
    is_last    = pool == PW'(POOLS - 1);
    at_cls     = CLS_W'(pool) == cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      area_start <= '0;
      for (int p = 0; p < POOLS; p++) begin
        maps[p] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we && (cfg_index == REG_AREA_START)) begin
        area_start <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            mode_r   <= mode_t'(s_tuser);
            addr_r   <= free_address;
            cls      <= cls_in;
            pool     <= '0;
            start    <= area_start;
            res_addr <= '0;
            if (mode_t'(s_tuser) == MODE_ALLOC && page_count == '0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else if (mode_t'(s_tuser) == MODE_ALLOC && cls_in >= CLS_W'(POOLS)) begin
              res_status <= ST_TOO_LARGE;
              state      <= S_DONE;
            end else begin
              state <= S_GAP;
            end
          end
        end
        S_GAP: begin
          gap   <= gap_in;
          state <= S_COUNT;
        end
        S_COUNT: begin
          first <= start + gap;
          count <= count_in;
          state <= S_TEST;
        end
        S_TEST: begin
          if (mode_r == MODE_ALLOC) begin
            if (!at_cls) begin
              pool  <= pool + PW'(1);
              start <= start + share;
              state <= S_GAP;
            end else if (|freebits) begin
              maps[pool][low_idx] <= 1'b1;
              res_addr            <= alloc_addr;
              res_status          <= ST_OK;
              state               <= S_DONE;
            end else begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end
          end else begin
            if (owned) begin
              if (aligned) begin
                maps[pool][blk[IW-1:0]] <= 1'b0;
                res_status              <= ST_OK;
              end else begin
                res_status <= ST_MISALIGNED;
              end
              state <= S_DONE;
            end else if (is_last) begin
              res_status <= ST_NOT_OWNED;
              state      <= S_DONE;
            end else begin
              pool  <= pool + PW'(1);
              start <= start + share;
              state <= S_GAP;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/scba_div.sv
// Divider that splits the area length by the pool count, one 16-bit digit per cycle.
`default_nettype none
module scba_div
  import scba_pkg::*;
#(
  parameter int DIVISOR = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output logic              busy,
  output logic [ADDR_W-1:0] quotient
);

  localparam int RW  = $clog2(DIVISOR) + 1;
  localparam int DW  = 16;
  localparam int TW  = DW + RW;
  localparam int SH  = TW + RW;
  localparam int MW  = SH + 1;
  localparam int PRW = TW + MW;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);

  logic [RW-1:0]  rem;
  logic [TW-1:0]  trial;
  logic [PRW-1:0] prod;
  logic [DW-1:0]  digit;
  logic [TW-1:0]  back;
  logic [1:0]     cnt;

  assign trial = {rem, quotient[ADDR_W-1 -: DW]};
  assign prod  = PRW'(trial) * PRW'(RECIP[MW-1:0]);
  assign digit = prod[SH +: DW];
  assign back  = trial - TW'(digit) * TW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rem      <= '0;
      quotient <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= back[RW-1:0];
      quotient <= {quotient[ADDR_W-DW-1:0], digit};
      cnt      <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the size class bitmap block allocator top level.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scba_pkg::*;

  localparam int POOLS         = 8;
  localparam int BLOCKS        = 64;
  localparam int PAGE_SHIFT    = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int DRAIN_CYCLES  = 3 * POOLS + 6;
  localparam int LONG_HOLD_AT  = 600;
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_CYCLES  = 1000000;

  typedef struct {
    mode_t       mode;
    logic [15:0] pages;
    logic [63:0] addr;
  } alloc_req_t;

  typedef struct {
    logic [63:0] addr;
    status_t     status;
  } alloc_reply_t;

  typedef struct {
    logic [63:0] base;
    logic [63:0] bsize;
    logic [63:0] count;
  } pool_geom_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  logic [63:0]  area_start_q = '0;
  logic [63:0]  area_bytes_q = '0;
  logic [63:0]  block_map [POOLS];
  alloc_req_t   request_q [$];
  alloc_reply_t reply_q [$];
  alloc_req_t   on_bus;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  hold_left = 0;
  int unsigned  stall_pct = 0;
  int unsigned  rx_cycles = 0;
  int unsigned  reply_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           long_hold_done = 1'b0;

  size_class_bitmap_block_allocator_top #(
    .POOLS(POOLS), .BLOCKS(BLOCKS), .PAGE_SHIFT(PAGE_SHIFT)
  ) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int p = 0; p < POOLS; p++) block_map[p] = '0;
  end

  function automatic pool_geom_t pool_geometry(int unsigned p);
    pool_geom_t g;
    logic [63:0] share, start, gap;
    share   = area_bytes_q / 64'(POOLS);
    start   = area_start_q + 64'(p) * share;
    g.bsize = 64'd1 << (p + PAGE_SHIFT);
    gap     = (g.bsize - (start & (g.bsize - 64'd1))) & (g.bsize - 64'd1);
    g.base  = start + gap;
    if (gap >= share) begin
      g.count = '0;
    end else begin
      g.count = (share - gap) / g.bsize;
      if (g.count > 64'(BLOCKS)) g.count = 64'(BLOCKS);
    end
    return g;
  endfunction

  function automatic alloc_reply_t allocate_or_free(alloc_req_t r);
    alloc_reply_t res;
    pool_geom_t   g;
    logic [63:0]  free_bits, offset, slot;
    int unsigned  cls, p;
    bit           owned;
    res.addr   = '0;
    res.status = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      if (r.pages == 16'd0) begin
        res.status = ST_ZERO;
      end else begin
        cls = 0;
        while (cls < 17 && (32'd1 << cls) < 32'(r.pages)) cls++;
        if (cls >= POOLS) begin
          res.status = ST_TOO_LARGE;
        end else begin
          g = pool_geometry(cls);
          free_bits = ~block_map[cls] &
                      ((g.count >= 64) ? {64{1'b1}} : ((64'd1 << g.count) - 64'd1));
          if (free_bits == '0) begin
            res.status = ST_FULL;
          end else begin
            slot = '0;
            while (!free_bits[slot[5:0]]) slot++;
            block_map[cls][slot[5:0]] = 1'b1;
            res.addr = g.base + slot * g.bsize;
          end
        end
      end
    end else begin
      res.status = ST_NOT_OWNED;
      owned = 1'b0;
      for (p = 0; p < POOLS && !owned; p++) begin
        g = pool_geometry(p);
        offset = r.addr - g.base;
        if (offset < g.count * g.bsize) begin
          owned = 1'b1;
          if ((offset & (g.bsize - 64'd1)) != '0) begin
            res.status = ST_MISALIGNED;
          end else begin
            slot = offset >> (p + PAGE_SHIFT);
            block_map[p][slot[5:0]] = 1'b0;
            res.status = ST_OK;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic alloc_req_t make_req(mode_t m, logic [15:0] pg, logic [63:0] a);
    alloc_req_t r;
    r.mode  = m;
    r.pages = pg;
    r.addr  = a;
    return r;
  endfunction

  // Mostly well-formed traffic: allocations spread over all size classes and frees of
  // block starts in the current geometry, with misaligned, out-of-range and raw noise.
  function automatic alloc_req_t random_request();
    alloc_req_t  r;
    pool_geom_t  g;
    int unsigned pick;
    logic [63:0] slot;
    r.pages = 16'($urandom);
    r.addr  = {$urandom, $urandom};
    pick    = $urandom_range(0, 99);
    if (pick < 50) begin
      r.mode = MODE_ALLOC;
      if (pick < 3) r.pages = '0;
      else if (pick >= 8) r.pages = 16'($urandom_range(1, 1 << $urandom_range(0, POOLS - 1)));
    end else begin
      r.mode = MODE_FREE;
      if (pick < 90) begin
        g = pool_geometry($urandom_range(0, POOLS - 1));
        if (g.count == '0) slot = 64'($urandom_range(0, 3));
        else slot = 64'($urandom_range(0, 32'(g.count) - ((pick >= 85) ? 0 : 1)));
        r.addr = g.base + slot * g.bsize;
        if (pick >= 80 && pick < 85) r.addr += 64'($urandom_range(1, 32'(g.bsize) - 1));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AREA_START) area_start_q = value;
    else area_bytes_q = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (request_q.size() != 0 || s_tvalid || reply_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : tx_side
    logic holding;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      holding = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) reply_q.push_back(allocate_or_free(on_bus));
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          on_bus = request_q.pop_front();
          s_tdata  <= {on_bus.addr, on_bus.pages};
          s_tuser  <= on_bus.mode;
          s_tvalid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rx_side
    alloc_reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer %h", m_tdata));
        end else begin
          want = reply_q.pop_front();
          if (m_tdata[ADDR_W-1:0] !== want.addr)
            report_mismatch($sformatf("block_address %h, expected %h",
                                      m_tdata[ADDR_W-1:0], want.addr));
          if (m_tdata[ADDR_W +: STATUS_W] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_tdata[ADDR_W +: STATUS_W], want.status));
        end
        reply_count++;
      end
      rx_cycles++;
      if (rx_cycles % 200 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      if (reply_count == LONG_HOLD_AT && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : sequencer
    pool_geom_t  g0, g3, g7;
    logic [63:0] a_start, a_bytes;
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With the reset geometry every pool is empty.
    request_q.push_back(make_req(MODE_ALLOC, 16'd0, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'hFFFF, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd129, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd128, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd1, '0));
    request_q.push_back(make_req(MODE_FREE, 16'd0, '0));
    request_q.push_back(make_req(MODE_FREE, 16'hFFFF, {64{1'b1}}));
    wait_drained();

    write_reg(REG_AREA_START, 64'h0000_0001_0000_0800);
    write_reg(REG_AREA_BYTES, 64'h0000_0000_2000_0000);
    @(negedge clk);
    g0 = pool_geometry(0);
    g3 = pool_geometry(3);
    g7 = pool_geometry(7);
    request_q.push_back(make_req(MODE_ALLOC, 16'd1, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd1, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd2, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd3, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd5, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd16, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd17, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd64, '0));
    request_q.push_back(make_req(MODE_ALLOC, 16'd128, '0));
    request_q.push_back(make_req(MODE_FREE, '0, g0.base));
    request_q.push_back(make_req(MODE_FREE, '0, g0.base));
    request_q.push_back(make_req(MODE_FREE, '0, g0.base + 64'h800));
    request_q.push_back(make_req(MODE_FREE, '0, g3.base + 64'd1));
    request_q.push_back(make_req(MODE_FREE, '0, g7.base + g7.count * g7.bsize));
    request_q.push_back(make_req(MODE_FREE, '0, area_start_q - 64'd1));
    request_q.push_back(make_req(MODE_ALLOC, 16'd1, '0));
    request_q.push_back(make_req(MODE_FREE, '0, g7.base));
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          a_start = {$urandom, $urandom} & ~64'hFFF;
          a_bytes = 64'($urandom_range(0, 32'h0400_0000));
        end
        1: begin
          a_start = '0;
          a_bytes = {64{1'b1}};
        end
        2: begin
          a_start = {64{1'b1}};
          a_bytes = {32'd0, $urandom};
        end
        3: begin
          a_bytes = 64'h1000_0000;
          a_start = 64'd0 - (a_bytes >> 1) + 64'($urandom_range(0, 4095));
        end
        4: begin
          a_start = '0;
          a_bytes = '0;
        end
        5: begin
          a_start = {$urandom, $urandom};
          a_bytes = {$urandom, $urandom};
        end
        6: begin
          a_start = {$urandom, $urandom};
          a_bytes = 64'($urandom_range(0, 32'h0020_0000));
        end
        default: begin
          a_start = {$urandom, $urandom};
          a_bytes = {$urandom, $urandom} >> $urandom_range(0, 40);
        end
      endcase
      write_reg(REG_AREA_START, a_start);
      write_reg(REG_AREA_BYTES, a_bytes);
      @(negedge clk);
      repeat (PHASE_ITEMS) request_q.push_back(random_request());
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
